>>> rtl/fsd_pkg.sv
// Shared types and stream code constants for the flux stream decoder.
package fsd_pkg;

  // Parser phase, one-hot.
  typedef enum logic [8:0] {
    PH_IDLE        = 9'b000000001,
    PH_FLUX2       = 9'b000000010,
    PH_FLUX3_HI    = 9'b000000100,
    PH_FLUX3_LO    = 9'b000001000,
    PH_NOP         = 9'b000010000,
    PH_OOB_TYPE    = 9'b000100000,
    PH_OOB_SIZE_LO = 9'b001000000,
    PH_OOB_SIZE_HI = 9'b010000000,
    PH_OOB_BODY    = 9'b100000000
  } phase_t;

  // Kinds of result item.
  typedef enum logic [2:0] {
    KIND_FLUX      = 3'd0,
    KIND_INDEX     = 3'd1,
    KIND_INFO      = 3'd2,
    KIND_READ_ERR  = 3'd3,
    KIND_END       = 3'd4
  } item_kind_t;

  // Stream code bytes.
  localparam logic [7:0] CODE_FLUX2_MAX = 8'h07;
  localparam logic [7:0] CODE_NOP1      = 8'h08;
  localparam logic [7:0] CODE_NOP2      = 8'h09;
  localparam logic [7:0] CODE_NOP3      = 8'h0a;
  localparam logic [7:0] CODE_OVL16     = 8'h0b;
  localparam logic [7:0] CODE_FLUX3     = 8'h0c;
  localparam logic [7:0] CODE_OOB       = 8'h0d;
  localparam logic [7:0] CODE_FLUX1_MIN = 8'h0e;

  // Out-of-band block types.
  localparam logic [7:0] OOB_NONE        = 8'h00;
  localparam logic [7:0] OOB_STREAM_INFO = 8'h01;
  localparam logic [7:0] OOB_INDEX       = 8'h02;
  localparam logic [7:0] OOB_STREAM_END  = 8'h03;
  localparam logic [7:0] OOB_INFO_TEXT   = 8'h04;
  localparam logic [7:0] OOB_EOF         = 8'h0d;

  // Required payload sizes.
  localparam logic [15:0] SIZE_SHORT_BLOCK = 16'd8;
  localparam logic [15:0] SIZE_INDEX_BLOCK = 16'd12;

  // Number of payload bytes kept (three words).
  localparam logic [3:0] PAYLOAD_KEEP = 4'd12;

  // Overflow step added by an Ovl16 code.
  localparam logic [16:0] OVL_STEP = 17'h10000;

endpackage

>>> rtl/flux_stream_decoder_unit.sv
// Flux stream decoder top level: byte parser with a registered result stage.
//
// Decodes a flux capture stream, one byte per request, into flux intervals,
// index records, stream-info records, nonzero read errors and an end record.
// Every byte is parsed in the cycle it is accepted, so while in_stall is low a
// new byte can be taken each clock; the parser state registers and the result
// register are the only storage. A byte yields at most one result, held in the
// output register until taken; in_stall rises only if it is full and stalled.
// A result shows in the cycle after its byte is accepted. A byte marked last
// returns the parser, overflow, flux count and end flag to their reset state.
module flux_stream_decoder_unit #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_item_kind,
  output logic [31:0] out_flux_interval,
  output logic [31:0] out_flux_position,
  output logic [31:0] out_stream_position,
  output logic [31:0] out_second_word,
  output logic [31:0] out_index_count,
  output logic        out_run_last
);

  localparam int VW1 = VALUE_WIDTH + 1;
  localparam int VX  = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 33;
  localparam int CX  = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

  // Saturate a sum that grew by one bit back to the value width.
  function automatic logic [VALUE_WIDTH-1:0] sat_value(input logic [VALUE_WIDTH:0] s);
    return s[VALUE_WIDTH] ? {VALUE_WIDTH{1'b1}} : s[VALUE_WIDTH-1:0];
  endfunction

  // Parser state.
  fsd_pkg::phase_t          phase_r, phase_nxt;
  logic [7:0]               high_r, high_nxt;
  logic [VALUE_WIDTH-1:0]   ovl_r, ovl_nxt;
  logic [7:0]               kind_r, kind_nxt;
  logic [15:0]              left_r, left_nxt;
  logic [7:0]               size_lo_r, size_lo_nxt;
  logic [3:0]               pos_r, pos_nxt;
  logic [95:0]              words_r, words_nxt;
  logic [COUNT_WIDTH-1:0]   total_r, total_nxt;
  logic                     ended_r, ended_nxt;

  // Result register.
  logic                     out_valid_r, out_valid_nxt;
  fsd_pkg::item_kind_t      res_kind_r, res_kind;
  logic [31:0]              res_interval_r, res_interval;
  logic [31:0]              res_fpos_r;
  logic [31:0]              res_spos_r, res_spos;
  logic [31:0]              res_second_r, res_second;
  logic [31:0]              res_icnt_r, res_icnt;

  logic                     accept;
  logic                     emit;
  logic                     emit_flux;
  logic                     finish;
  logic [15:0]              flux_raw;
  logic [15:0]              block_size;
  logic [VALUE_WIDTH-1:0]   flux_val;
  logic [VX-1:0]            flux_ext;
  logic [CX-1:0]            total_ext;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign block_size = {in_byte, size_lo_r};
  assign flux_val   = sat_value(VW1'(flux_raw) + VW1'(ovl_r));
  assign flux_ext   = VX'(flux_val);
  assign total_ext  = CX'(total_r);

  // Byte parser: next state and result for the byte at the input.
  always_comb begin
    phase_nxt   = phase_r;
    high_nxt    = high_r;
    ovl_nxt     = ovl_r;
    kind_nxt    = kind_r;
    left_nxt    = left_r;
    size_lo_nxt = size_lo_r;
    pos_nxt     = pos_r;
    words_nxt   = words_r;
    total_nxt   = total_r;
    ended_nxt   = ended_r;
    emit        = 1'b0;
    emit_flux   = 1'b0;
    finish      = 1'b0;
    flux_raw    = 16'd0;
    res_kind    = fsd_pkg::KIND_FLUX;
    res_interval = 32'd0;
    res_spos    = 32'd0;
    res_second  = 32'd0;
    res_icnt    = 32'd0;

    if (!ended_r) begin
      unique case (phase_r)
        fsd_pkg::PH_IDLE: begin
          if (in_byte >= fsd_pkg::CODE_FLUX1_MIN) begin
            emit_flux = 1'b1;
            flux_raw  = {8'd0, in_byte};
          end else if (in_byte <= fsd_pkg::CODE_FLUX2_MAX) begin
            high_nxt  = in_byte;
            phase_nxt = fsd_pkg::PH_FLUX2;
          end else if (in_byte == fsd_pkg::CODE_NOP2) begin
            left_nxt  = 16'd1;
            phase_nxt = fsd_pkg::PH_NOP;
          end else if (in_byte == fsd_pkg::CODE_NOP3) begin
            left_nxt  = 16'd2;
            phase_nxt = fsd_pkg::PH_NOP;
          end else if (in_byte == fsd_pkg::CODE_OVL16) begin
            ovl_nxt = sat_value(VW1'(ovl_r) + VW1'(fsd_pkg::OVL_STEP));
          end else if (in_byte == fsd_pkg::CODE_FLUX3) begin
            phase_nxt = fsd_pkg::PH_FLUX3_HI;
          end else if (in_byte == fsd_pkg::CODE_OOB) begin
            phase_nxt = fsd_pkg::PH_OOB_TYPE;
          end
          // A single-byte Nop needs no action.
        end
        fsd_pkg::PH_FLUX2, fsd_pkg::PH_FLUX3_LO: begin
          emit_flux = 1'b1;
          flux_raw  = {high_r, in_byte};
        end
        fsd_pkg::PH_FLUX3_HI: begin
          high_nxt  = in_byte;
          phase_nxt = fsd_pkg::PH_FLUX3_LO;
        end
        fsd_pkg::PH_NOP: begin
          left_nxt = left_r - 16'd1;
          if (left_r <= 16'd1) begin
            left_nxt  = 16'd0;
            phase_nxt = fsd_pkg::PH_IDLE;
          end
        end
        fsd_pkg::PH_OOB_TYPE: begin
          if (in_byte == fsd_pkg::OOB_EOF) begin
            ended_nxt = 1'b1;
            phase_nxt = fsd_pkg::PH_IDLE;
            emit      = 1'b1;
            res_kind  = fsd_pkg::KIND_END;
          end else begin
            kind_nxt  = in_byte;
            phase_nxt = fsd_pkg::PH_OOB_SIZE_LO;
          end
        end
        fsd_pkg::PH_OOB_SIZE_LO: begin
          size_lo_nxt = in_byte;
          phase_nxt   = fsd_pkg::PH_OOB_SIZE_HI;
        end
        fsd_pkg::PH_OOB_SIZE_HI: begin
          // Only blocks of the expected size keep their type.
          if (!(((kind_r == fsd_pkg::OOB_STREAM_INFO || kind_r == fsd_pkg::OOB_STREAM_END) &&
                 block_size == fsd_pkg::SIZE_SHORT_BLOCK) ||
                (kind_r == fsd_pkg::OOB_INDEX && block_size == fsd_pkg::SIZE_INDEX_BLOCK))) begin
            kind_nxt = fsd_pkg::OOB_NONE;
          end
          words_nxt = 96'd0;
          pos_nxt   = 4'd0;
          left_nxt  = block_size;
          if (block_size == 16'd0) begin
            finish = 1'b1;
          end else begin
            phase_nxt = fsd_pkg::PH_OOB_BODY;
          end
        end
        fsd_pkg::PH_OOB_BODY: begin
          if (pos_r < fsd_pkg::PAYLOAD_KEEP) begin
            words_nxt[{pos_r, 3'b000} +: 8] = in_byte;
            pos_nxt = pos_r + 4'd1;
          end
          left_nxt = left_r - 16'd1;
          if (left_r == 16'd1) begin
            finish = 1'b1;
          end
        end
        default: begin
          phase_nxt = fsd_pkg::PH_IDLE;
        end
      endcase

      // Flux interval: overflow folded in, then cleared.
      if (emit_flux) begin
        emit         = 1'b1;
        res_kind     = fsd_pkg::KIND_FLUX;
        res_interval = (|flux_ext[VX-1:32]) ? 32'hffff_ffff : flux_ext[31:0];
        ovl_nxt      = '0;
        total_nxt    = total_r + COUNT_WIDTH'(1);
        phase_nxt    = fsd_pkg::PH_IDLE;
      end

      // End of an out-of-band block.
      if (finish) begin
        phase_nxt  = fsd_pkg::PH_IDLE;
        res_spos   = words_nxt[31:0];
        res_second = words_nxt[63:32];
        if (kind_nxt == fsd_pkg::OOB_STREAM_INFO) begin
          emit     = 1'b1;
          res_kind = fsd_pkg::KIND_INFO;
        end else if (kind_nxt == fsd_pkg::OOB_INDEX) begin
          emit     = 1'b1;
          res_kind = fsd_pkg::KIND_INDEX;
          res_icnt = words_nxt[95:64];
        end else if (kind_nxt == fsd_pkg::OOB_STREAM_END && words_nxt[63:32] != 32'd0) begin
          emit     = 1'b1;
          res_kind = fsd_pkg::KIND_READ_ERR;
        end
      end
    end

    // The last byte of a buffer returns the parser to its reset state.
    if (in_last_byte) begin
      phase_nxt   = fsd_pkg::PH_IDLE;
      high_nxt    = 8'd0;
      ovl_nxt     = '0;
      kind_nxt    = fsd_pkg::OOB_NONE;
      left_nxt    = 16'd0;
      size_lo_nxt = 8'd0;
      pos_nxt     = 4'd0;
      words_nxt   = 96'd0;
      total_nxt   = '0;
      ended_nxt   = 1'b0;
    end
  end

  // Output register occupancy.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= fsd_pkg::PH_IDLE;
      high_r    <= 8'd0;
      ovl_r     <= '0;
      kind_r    <= fsd_pkg::OOB_NONE;
      left_r    <= 16'd0;
      size_lo_r <= 8'd0;
      pos_r     <= 4'd0;
      words_r   <= 96'd0;
      total_r   <= '0;
      ended_r   <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      high_r    <= high_nxt;
      ovl_r     <= ovl_nxt;
      kind_r    <= kind_nxt;
      left_r    <= left_nxt;
      size_lo_r <= size_lo_nxt;
      pos_r     <= pos_nxt;
      words_r   <= words_nxt;
      total_r   <= total_nxt;
      ended_r   <= ended_nxt;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_kind_r     <= res_kind;
      res_interval_r <= res_interval;
      res_fpos_r     <= total_ext[31:0];
      res_spos_r     <= res_spos;
      res_second_r   <= res_second;
      res_icnt_r     <= res_icnt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_item_kind       = res_kind_r;
  assign out_flux_interval   = res_interval_r;
  assign out_flux_position   = res_fpos_r;
  assign out_stream_position = res_spos_r;
  assign out_second_word     = res_second_r;
  assign out_index_count     = res_icnt_r;
  assign out_run_last        = 1'b1;

  // Once the end record is seen the parser rests in idle.
  a_ended_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> (phase_r == fsd_pkg::PH_IDLE))
    else $error("end flag set outside idle phase");

  // A flux result carries no block words.
  a_flux_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_kind_r == fsd_pkg::KIND_FLUX) |->
      (res_spos_r == 32'd0 && res_second_r == 32'd0 && res_icnt_r == 32'd0))
    else $error("flux result with block words");

  // A flux interval advances the count and clears the overflow.
  a_flux_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit_flux && !in_last_byte) |=>
      (total_r == $past(total_r) + COUNT_WIDTH'(1) && ovl_r == '0))
    else $error("flux count or overflow not updated");

  // A result is never dropped: a stalled full register holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(res_interval_r) &&
      $stable(res_fpos_r)))
    else $error("stalled result changed");

endmodule

>>> dv/tb_flux_stream_decoder_unit.sv
// Self-checking testbench for the flux stream decoder with a built-in decoding predictor.
`timescale 1ns / 1ps

module tb_flux_stream_decoder_unit;

  localparam int VALUE_W = 32;
  localparam int CYCLE_LIMIT = 40000;
  localparam int RANDOM_BYTES = 510;

  // One stream byte waiting to be sent, with its end-of-buffer mark.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  // One decoded record as it leaves the block.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] interval;
    logic [31:0] position;
    logic [31:0] spos;
    logic [31:0] second;
    logic [31:0] icnt;
    logic        run_last;
  } decoded_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_item_kind;
  logic [31:0] out_flux_interval;
  logic [31:0] out_flux_position;
  logic [31:0] out_stream_position;
  logic [31:0] out_second_word;
  logic [31:0] out_index_count;
  logic        out_run_last;

  stream_byte_t stream_bytes[$];
  decoded_rec_t expected_records[$];
  int           cycle_cnt = 0;
  int           mismatches = 0;
  int           random_count;

  // Decoder state mirrored by the predictor.
  fsd_pkg::phase_t dec_phase;
  logic [7:0]      dec_high;
  logic [63:0]     dec_overflow;
  logic [7:0]      dec_block;
  logic [15:0]     dec_left;
  logic [15:0]     dec_size;
  logic [31:0]     dec_words[3];
  logic [31:0]     dec_flux_count;
  bit              dec_ended;

  flux_stream_decoder_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item_kind(out_item_kind),
    .out_flux_interval(out_flux_interval),
    .out_flux_position(out_flux_position),
    .out_stream_position(out_stream_position),
    .out_second_word(out_second_word),
    .out_index_count(out_index_count),
    .out_run_last(out_run_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Returns the decoder to its reset state.
  task automatic clear_decoder();
    dec_phase = fsd_pkg::PH_IDLE;
    dec_high = 8'h00;
    dec_overflow = 64'd0;
    dec_block = 8'h00;
    dec_left = 16'd0;
    dec_size = 16'd0;
    dec_words[0] = 32'd0;
    dec_words[1] = 32'd0;
    dec_words[2] = 32'd0;
    dec_flux_count = 32'd0;
    dec_ended = 1'b0;
  endtask

  // Adds two values, saturating at the value width.
  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [63:0] m;
    m = (64'd1 << VALUE_W) - 64'd1;
    if (a > m) a = m;
    if (b > m) b = m;
    if (a > m - b) return m;
    return a + b;
  endfunction

  task automatic add_record(logic [2:0] kind, logic [63:0] interval, logic [31:0] spos,
                            logic [31:0] second, logic [31:0] icnt);
    decoded_rec_t r;
    r.kind = kind;
    r.interval = (interval > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : interval[31:0];
    r.position = dec_flux_count;
    r.spos = spos;
    r.second = second;
    r.icnt = icnt;
    r.run_last = 1'b1;
    expected_records.push_back(r);
  endtask

  task automatic add_flux(logic [63:0] raw);
    add_record(fsd_pkg::KIND_FLUX, sat_sum(raw, dec_overflow), 32'd0, 32'd0, 32'd0);
    dec_overflow = 64'd0;
    dec_flux_count = dec_flux_count + 32'd1;
    dec_phase = fsd_pkg::PH_IDLE;
  endtask

  // Closes an out-of-band block; only well-sized known blocks give a record.
  task automatic close_block();
    dec_phase = fsd_pkg::PH_IDLE;
    if (dec_block == fsd_pkg::OOB_STREAM_INFO) begin
      add_record(fsd_pkg::KIND_INFO, 64'd0, dec_words[0], dec_words[1], 32'd0);
    end else if (dec_block == fsd_pkg::OOB_INDEX) begin
      add_record(fsd_pkg::KIND_INDEX, 64'd0, dec_words[0], dec_words[1], dec_words[2]);
    end else if (dec_block == fsd_pkg::OOB_STREAM_END && dec_words[1] != 32'd0) begin
      add_record(fsd_pkg::KIND_READ_ERR, 64'd0, dec_words[0], dec_words[1], 32'd0);
    end
  endtask

  // Predicts the records caused by one accepted stream byte.
  task automatic decode_byte(logic [7:0] b, logic last);
    logic [15:0] pos;
    if (!dec_ended) begin
      case (dec_phase)
        fsd_pkg::PH_IDLE: begin
          if (b >= fsd_pkg::CODE_FLUX1_MIN) begin
            add_flux({56'd0, b});
          end else if (b <= fsd_pkg::CODE_FLUX2_MAX) begin
            dec_high = b;
            dec_phase = fsd_pkg::PH_FLUX2;
          end else if (b == fsd_pkg::CODE_NOP2 || b == fsd_pkg::CODE_NOP3) begin
            dec_left = {8'd0, b - fsd_pkg::CODE_NOP1};
            dec_phase = fsd_pkg::PH_NOP;
          end else if (b == fsd_pkg::CODE_OVL16) begin
            dec_overflow = sat_sum(dec_overflow, {47'd0, fsd_pkg::OVL_STEP});
          end else if (b == fsd_pkg::CODE_FLUX3) begin
            dec_phase = fsd_pkg::PH_FLUX3_HI;
          end else if (b == fsd_pkg::CODE_OOB) begin
            dec_phase = fsd_pkg::PH_OOB_TYPE;
          end
        end
        fsd_pkg::PH_FLUX2, fsd_pkg::PH_FLUX3_LO: add_flux({48'd0, dec_high, b});
        fsd_pkg::PH_FLUX3_HI: begin
          dec_high = b;
          dec_phase = fsd_pkg::PH_FLUX3_LO;
        end
        fsd_pkg::PH_NOP: begin
          if (dec_left > 0) dec_left = dec_left - 16'd1;
          if (dec_left == 0) dec_phase = fsd_pkg::PH_IDLE;
        end
        fsd_pkg::PH_OOB_TYPE: begin
          if (b == fsd_pkg::OOB_EOF) begin
            dec_ended = 1'b1;
            dec_phase = fsd_pkg::PH_IDLE;
            add_record(fsd_pkg::KIND_END, 64'd0, 32'd0, 32'd0, 32'd0);
          end else begin
            dec_block = b;
            dec_phase = fsd_pkg::PH_OOB_SIZE_LO;
          end
        end
        fsd_pkg::PH_OOB_SIZE_LO: begin
          dec_size = {8'd0, b};
          dec_phase = fsd_pkg::PH_OOB_SIZE_HI;
        end
        fsd_pkg::PH_OOB_SIZE_HI: begin
          dec_size[15:8] = b;
          // A known block with the wrong size is skipped like an unknown one.
          if (!(((dec_block == fsd_pkg::OOB_STREAM_INFO ||
                  dec_block == fsd_pkg::OOB_STREAM_END) &&
                 dec_size == fsd_pkg::SIZE_SHORT_BLOCK) ||
                (dec_block == fsd_pkg::OOB_INDEX &&
                 dec_size == fsd_pkg::SIZE_INDEX_BLOCK)))
            dec_block = fsd_pkg::OOB_NONE;
          dec_words[0] = 32'd0;
          dec_words[1] = 32'd0;
          dec_words[2] = 32'd0;
          dec_left = dec_size;
          if (dec_left == 0) close_block();
          else dec_phase = fsd_pkg::PH_OOB_BODY;
        end
        fsd_pkg::PH_OOB_BODY: begin
          pos = dec_size - dec_left;
          if (pos < 16'd12) dec_words[pos[3:2]] |= {24'd0, b} << (pos[1:0] * 8);
          dec_left = dec_left - 16'd1;
          if (dec_left == 0) close_block();
        end
        default: dec_phase = fsd_pkg::PH_IDLE;
      endcase
    end
    if (last) clear_decoder();
  endtask

  // Stimulus helpers.
  task automatic push_byte(logic [7:0] b, logic last);
    stream_byte_t s;
    s.data = b;
    s.last = last;
    stream_bytes.push_back(s);
  endtask

  // A random-phase byte carries an occasional end-of-buffer mark that cuts sequences short.
  task automatic push_rand(logic [7:0] b);
    push_byte(b, $urandom_range(0, 199) < 3);
    random_count++;
  endtask

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_block(logic [7:0] kind, logic [15:0] size, bit zero_code);
    push_rand(fsd_pkg::CODE_OOB);
    push_rand(kind);
    push_rand(size[7:0]);
    push_rand(size[15:8]);
    for (int i = 0; i < size; i++) begin
      push_rand((zero_code && i >= 4) ? 8'h00 : rand_byte());
    end
  endtask

  // Appends one well-formed sequence with random content, or a little noise.
  task automatic push_sequence();
    int k;
    logic [7:0] t;
    logic [15:0] sz;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 17: push_rand(8'($urandom_range(14, 255)));
      4, 5, 18: begin
        push_rand(8'($urandom_range(0, 7)));
        push_rand(rand_byte());
      end
      6, 19: begin
        push_rand(fsd_pkg::CODE_FLUX3);
        push_rand(rand_byte());
        push_rand(rand_byte());
      end
      7: begin
        k = $urandom_range(0, 2);
        push_rand(8'(fsd_pkg::CODE_NOP1 + k));
        repeat (k) push_rand(rand_byte());
      end
      8: begin
        repeat ($urandom_range(1, 3)) push_rand(fsd_pkg::CODE_OVL16);
        if ($urandom_range(0, 1)) push_rand(fsd_pkg::CODE_NOP1);
        push_rand(8'($urandom_range(14, 255)));
      end
      9: push_block(fsd_pkg::OOB_STREAM_INFO, fsd_pkg::SIZE_SHORT_BLOCK, 1'b0);
      10: push_block(fsd_pkg::OOB_INDEX, fsd_pkg::SIZE_INDEX_BLOCK, 1'b0);
      11: push_block(fsd_pkg::OOB_STREAM_END, fsd_pkg::SIZE_SHORT_BLOCK,
                     $urandom_range(0, 9) < 3);
      12: begin
        // Known block type with a size it does not allow.
        t = 8'($urandom_range(1, 3));
        do sz = 16'($urandom_range(0, 20));
        while (sz == ((t == fsd_pkg::OOB_INDEX) ? fsd_pkg::SIZE_INDEX_BLOCK :
                                                  fsd_pkg::SIZE_SHORT_BLOCK));
        if ($urandom_range(0, 7) == 0) sz = 16'd256 + 16'($urandom_range(0, 40));
        push_block(t, sz, 1'b0);
      end
      13: begin
        // Type zero, info text and unknown types are all skipped.
        k = $urandom_range(0, 2);
        if (k == 0) t = fsd_pkg::OOB_NONE;
        else if (k == 1) t = fsd_pkg::OOB_INFO_TEXT;
        else do t = 8'($urandom_range(5, 255)); while (t == fsd_pkg::OOB_EOF);
        sz = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 16)) :
             (($urandom_range(0, 1)) ? fsd_pkg::SIZE_SHORT_BLOCK :
                                       fsd_pkg::SIZE_INDEX_BLOCK);
        push_block(t, sz, 1'b0);
      end
      14: begin
        // End of stream, some ignored bytes, then the end of the buffer.
        push_rand(fsd_pkg::CODE_OOB);
        push_rand(fsd_pkg::OOB_EOF);
        repeat ($urandom_range(0, 4)) push_rand(rand_byte());
        push_byte(rand_byte(), 1'b1);
        random_count++;
      end
      default: begin
        repeat ($urandom_range(1, 3)) begin
          do t = 8'($urandom_range(0, 255)); while (t == fsd_pkg::CODE_OOB);
          push_rand(t);
        end
      end
    endcase
  endtask

  // Random idling, with a quiet window early in the random part.
  function automatic bit idle_now();
    if (cycle_cnt >= 150 && cycle_cnt < 550) return 1'b0;
    return $urandom_range(0, 99) < 27;
  endfunction

  // Request driver: holds a stalled request, otherwise offers the next byte.
  always @(posedge clk) begin : drive_requests
    bit fire;
    stream_byte_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_byte <= 8'h00;
      in_last_byte <= 1'b0;
      clear_decoder();
    end else begin
      fire = in_valid && !in_stall;
      if (fire) decode_byte(in_byte, in_last_byte);
      if (in_valid && !fire) begin
        in_valid <= 1'b1;
      end else if (stream_bytes.size() != 0 && !idle_now()) begin
        s = stream_bytes.pop_front();
        in_valid <= 1'b1;
        in_byte <= s.data;
        in_last_byte <= s.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stall.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= idle_now();
  end

  // Result monitor: compares each accepted record with the oldest prediction.
  always @(posedge clk) begin : check_records
    decoded_rec_t got;
    decoded_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_item_kind, out_flux_interval, out_flux_position, out_stream_position,
             out_second_word, out_index_count, out_run_last};
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected record: kind %0d interval %h position %0d", got.kind,
                   got.interval, got.position);
      end else begin
        want = expected_records.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Record mismatch at cycle %0d", cycle_cnt);
            $display({"  expected kind %0d interval %h position %0d spos %h second %h",
                      " icnt %h last %b"},
                     want.kind, want.interval, want.position, want.spos, want.second,
                     want.icnt, want.run_last);
            $display({"  actual   kind %0d interval %h position %0d spos %h second %h",
                      " icnt %h last %b"},
                     got.kind, got.interval, got.position, got.spos, got.second,
                     got.icnt, got.run_last);
          end
        end
      end
    end
  end

  // Cycle counter and run timeout.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    // Directed: field extremes, every code, skipping, overflow, end and truncation.
    push_byte(fsd_pkg::CODE_FLUX1_MIN, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(fsd_pkg::CODE_FLUX2_MAX, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(fsd_pkg::CODE_NOP1, 1'b0);
    push_byte(fsd_pkg::CODE_NOP2, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(fsd_pkg::CODE_NOP3, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'h0C, 1'b0);
    push_byte(fsd_pkg::CODE_OVL16, 1'b0);
    push_byte(fsd_pkg::CODE_OVL16, 1'b0);
    push_byte(fsd_pkg::CODE_NOP1, 1'b0);
    push_byte(fsd_pkg::CODE_FLUX1_MIN, 1'b0);
    push_byte(fsd_pkg::CODE_FLUX3, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(fsd_pkg::CODE_FLUX3, 1'b0);
    push_byte(8'h12, 1'b1);
    push_byte(fsd_pkg::CODE_OOB, 1'b0);
    push_byte(fsd_pkg::OOB_EOF, 1'b0);
    push_byte(8'h42, 1'b0);
    push_byte(fsd_pkg::CODE_FLUX1_MIN, 1'b1);

    // Random sequences.
    random_count = 0;
    while (random_count < RANDOM_BYTES) push_sequence();

    // Overflow gathered over several codes and a Nop, then a full Flux3.
    push_byte(fsd_pkg::CODE_FLUX1_MIN, 1'b1);
    repeat (4) push_byte(fsd_pkg::CODE_OVL16, 1'b0);
    push_byte(fsd_pkg::CODE_NOP2, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(fsd_pkg::CODE_FLUX3, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (stream_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
